[design/sntseq_pkg.sv]
// sntseq_pkg: shared types and constants for the SPI NAND transfer sequencer
// holds the phase encoding, the frame descriptor struct and the command bytes
// no dependencies
package sntseq_pkg;

    // word opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;

    // SPI NAND command bytes
    localparam logic [7:0] CMD_PAGE_READ = 8'h13;
    localparam logic [7:0] CMD_CACHE_RD  = 8'h03;
    localparam logic [7:0] CMD_WREN      = 8'h06;
    localparam logic [7:0] CMD_PROG_LOAD = 8'h02;
    localparam logic [7:0] CMD_PROG_EXEC = 8'h10;
    localparam logic [7:0] CMD_GET_FEAT  = 8'h0f;
    localparam logic [7:0] STATUS_REG    = 8'hc0;

    // minimum page size and reset value
    localparam logic [3:0] MIN_PAGE_LOG2   = 4'd9;
    localparam logic [3:0] RESET_PAGE_LOG2 = 4'd11;

    localparam int DATA_W = 14;

    // sequencer phases, one-hot
    typedef enum logic [10:0] {
        PH_IDLE    = 11'b000_0000_0001,
        PH_R_PAGE  = 11'b000_0000_0010,
        PH_R_POLLA = 11'b000_0000_0100,
        PH_R_CACHE = 11'b000_0000_1000,
        PH_R_POLLB = 11'b000_0001_0000,
        PH_W_WREN  = 11'b000_0010_0000,
        PH_W_POLLA = 11'b000_0100_0000,
        PH_W_LOAD  = 11'b000_1000_0000,
        PH_W_POLLB = 11'b001_0000_0000,
        PH_W_EXEC  = 11'b010_0000_0000,
        PH_W_POLLC = 11'b100_0000_0000
    } t_phase;

    // description of one SPI frame
    typedef struct packed {
        logic [7:0]        cmd;
        logic [23:0]       hdr_value;
        logic [1:0]        hdr_bytes;
        logic [DATA_W-1:0] data_bytes;
        logic              from_dev;
        logic [31:0]       offset;
    } t_frame;

    // phase that follows a successful step within a chunk
    function automatic t_phase next_phase(input t_phase ph);
        t_phase nx;
        nx = PH_IDLE;
        unique case (ph)
            PH_R_PAGE:  nx = PH_R_POLLA;
            PH_R_POLLA: nx = PH_R_CACHE;
            PH_R_CACHE: nx = PH_R_POLLB;
            PH_W_WREN:  nx = PH_W_POLLA;
            PH_W_POLLA: nx = PH_W_LOAD;
            PH_W_LOAD:  nx = PH_W_POLLB;
            PH_W_POLLB: nx = PH_W_EXEC;
            PH_W_EXEC:  nx = PH_W_POLLC;
            default:    nx = PH_IDLE;
        endcase
        return nx;
    endfunction

endpackage

[design/sntseq_frame.sv]
// sntseq_frame: builds the frame descriptor for a sequencer phase
// depends on sntseq_pkg (t_phase, t_frame, command bytes)
module sntseq_frame import sntseq_pkg::*; #(
    parameter int MAX_PAGE_LOG2 = 13
) (
    input  t_phase                   i_phase,
    input  logic [31:0]              i_address,
    input  logic [MAX_PAGE_LOG2:0]   i_chunk,
    input  logic [31:0]              i_total,
    input  logic [3:0]               i_page_log2,
    output t_frame                   o_frame
);

    localparam int CW = MAX_PAGE_LOG2 + 1;

    logic [CW-1:0]            page_span;
    logic [MAX_PAGE_LOG2-1:0] col;
    logic [23:0]              page;

    // page number and column under the current page size
    assign page_span = CW'(1) << i_page_log2;
    assign col       = i_address[MAX_PAGE_LOG2-1:0] & (page_span[MAX_PAGE_LOG2-1:0] -
                       MAX_PAGE_LOG2'(1));
    assign page      = 24'(i_address >> i_page_log2);

    // frame fields per phase, busy poll for the poll phases
    always_comb begin
        o_frame = '0;
        unique case (i_phase)
            PH_R_PAGE: begin
                o_frame.cmd       = CMD_PAGE_READ;
                o_frame.hdr_value = page;
                o_frame.hdr_bytes = 2'd3;
            end
            PH_R_CACHE: begin
                o_frame.cmd        = CMD_CACHE_RD;
                o_frame.hdr_value  = 24'(col) << 8;
                o_frame.hdr_bytes  = 2'd3;
                o_frame.data_bytes = DATA_W'(i_chunk);
                o_frame.from_dev   = 1'b1;
                o_frame.offset     = i_total;
            end
            PH_W_WREN: begin
                o_frame.cmd = CMD_WREN;
            end
            PH_W_LOAD: begin
                o_frame.cmd        = CMD_PROG_LOAD;
                o_frame.hdr_value  = 24'(col);
                o_frame.hdr_bytes  = 2'd2;
                o_frame.data_bytes = DATA_W'(i_chunk);
                o_frame.offset     = i_total;
            end
            PH_W_EXEC: begin
                o_frame.cmd       = CMD_PROG_EXEC;
                o_frame.hdr_value = page;
                o_frame.hdr_bytes = 2'd3;
            end
            default: begin
                o_frame.cmd        = CMD_GET_FEAT;
                o_frame.hdr_value  = 24'(STATUS_REG);
                o_frame.hdr_bytes  = 2'd1;
                o_frame.data_bytes = DATA_W'(1);
                o_frame.from_dev   = 1'b1;
            end
        endcase
    end

endmodule

[design/spi_nand_transfer_sequencer_top.sv]
// spi_nand_transfer_sequencer_top: page read / program sequencer for SPI NAND
// depends on sntseq_pkg and sntseq_frame
//
// Accepts one word per cycle while the input side is not stalled: a read or write
// request, or a completion report of the last issued frame. Each accepted word is
// latched in an input register, decided against the sequencer state, and any frame
// or finish word is placed in an output register. While a result waits, the input
// register takes one more word and then the input side stalls until the result is
// taken. Requests are cut at page boundaries (page size from the page_size_log2
// register, clamped to 9..MAX_PAGE_LOG2); per chunk a read issues page-to-cache,
// poll, cache read, poll and a write issues write enable, poll, program load, poll,
// program execute, poll. Polls repeat while the report is ok and status bit 0 is
// set. A failed command frame finishes the request early.
module spi_nand_transfer_sequencer_top import sntseq_pkg::*; #(
    parameter int MAX_PAGE_LOG2 = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    // input words
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_byte_address,
    input  logic [31:0] i_byte_count,
    input  logic        i_frame_ok,
    input  logic [7:0]  i_status_byte,
    // result words
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_command_byte,
    output logic [23:0] o_header_value,
    output logic [1:0]  o_header_bytes,
    output logic [13:0] o_data_bytes,
    output logic        o_data_from_device,
    output logic [31:0] o_buffer_offset,
    output logic [31:0] o_bytes_moved,
    output logic        o_ended_early
);

    localparam int CW = MAX_PAGE_LOG2 + 1;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic [31:0] r_in_addr;
    logic [31:0] r_in_count;
    logic        r_in_ok;
    logic        r_in_stat0;

    // sequencer state
    logic [3:0]  r_log2;
    t_phase      r_phase,   n_phase;
    logic        r_write_mode, n_write_mode;
    logic [31:0] r_next_address, n_next_address;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [31:0] r_total_moved, n_total_moved;
    logic [CW-1:0] r_chunk, n_chunk;

    // end-of-chunk values, precomputed from the settled state
    logic [31:0] r_addr_after;
    logic [31:0] r_left_after;
    logic [31:0] r_total_after;

    // output register
    logic        r_out_valid;
    logic        r_out_kind;
    t_frame      r_out_frame;
    logic [31:0] r_out_moved;
    logic        r_out_early;

    logic              proc;
    logic [3:0]        eff_log2;
    logic [31:0]       base_addr;
    logic [31:0]       base_left;
    logic [CW-1:0]     page_span;
    logic [MAX_PAGE_LOG2-1:0] base_col;
    logic [CW-1:0]     room;
    logic [CW-1:0]     chunk_new;
    logic              busy;
    logic              res_valid;
    logic              res_finish;
    logic              res_early;
    t_frame            frame;

    // handshake: decide the held word when the output register can take a result
    assign proc    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op    <= i_opcode;
            r_in_addr  <= i_byte_address;
            r_in_count <= i_byte_count;
            r_in_ok    <= i_frame_ok;
            r_in_stat0 <= i_status_byte[0];
        end
    end

    // page size register and clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= RESET_PAGE_LOG2;
        end else if (i_cfg_we) begin
            r_log2 <= i_cfg_wdata;
        end
    end

    always_comb begin
        eff_log2 = r_log2;
        if (r_log2 < MIN_PAGE_LOG2) begin
            eff_log2 = MIN_PAGE_LOG2;
        end
        if (r_log2 > 4'(MAX_PAGE_LOG2)) begin
            eff_log2 = 4'(MAX_PAGE_LOG2);
        end
    end

    // chunk size for a new chunk: from the request when idle, else after the last chunk
    assign base_addr = (r_phase == PH_IDLE) ? r_in_addr  : r_addr_after;
    assign base_left = (r_phase == PH_IDLE) ? r_in_count : r_left_after;
    assign page_span = CW'(1) << eff_log2;
    assign base_col  = base_addr[MAX_PAGE_LOG2-1:0] &
                       (page_span[MAX_PAGE_LOG2-1:0] - MAX_PAGE_LOG2'(1));
    assign room      = page_span - CW'(base_col);
    assign chunk_new = (base_left < 32'(room)) ? CW'(base_left) : room;

    assign busy = r_in_ok && r_in_stat0;

    // step decision for the held word
    always_comb begin
        n_phase        = r_phase;
        n_write_mode   = r_write_mode;
        n_next_address = r_next_address;
        n_bytes_left   = r_bytes_left;
        n_total_moved  = r_total_moved;
        n_chunk        = r_chunk;
        res_valid      = 1'b0;
        res_finish     = 1'b0;
        res_early      = 1'b0;
        if (r_in_op == OP_READ || r_in_op == OP_WRITE) begin
            if (r_phase == PH_IDLE) begin
                res_valid      = 1'b1;
                n_write_mode   = (r_in_op == OP_WRITE);
                n_next_address = r_in_addr;
                n_bytes_left   = r_in_count;
                n_total_moved  = '0;
                if (r_in_count == '0) begin
                    n_chunk    = '0;
                    res_finish = 1'b1;
                end else begin
                    n_chunk = chunk_new;
                    n_phase = (r_in_op == OP_WRITE) ? PH_W_WREN : PH_R_PAGE;
                end
            end
        end else if (r_in_op == OP_DONE && r_phase != PH_IDLE) begin
            res_valid = 1'b1;
            unique case (r_phase) inside
                PH_R_PAGE, PH_R_CACHE, PH_W_WREN, PH_W_LOAD, PH_W_EXEC: begin
                    if (!r_in_ok) begin
                        res_finish = 1'b1;
                        res_early  = 1'b1;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_phase = next_phase(r_phase);
                    end
                end
                PH_R_POLLA, PH_W_POLLA, PH_W_POLLB: begin
                    if (!busy) begin
                        n_phase = next_phase(r_phase);
                    end
                end
                PH_R_POLLB, PH_W_POLLC: begin
                    if (!busy) begin
                        n_next_address = r_addr_after;
                        n_total_moved  = r_total_after;
                        n_bytes_left   = r_left_after;
                        if (r_left_after == '0) begin
                            res_finish = 1'b1;
                            n_phase    = PH_IDLE;
                        end else begin
                            n_chunk = chunk_new;
                            n_phase = r_write_mode ? PH_W_WREN : PH_R_PAGE;
                        end
                    end
                end
                default: begin
                    res_valid = 1'b0;
                    n_phase   = PH_IDLE;
                end
            endcase
        end
    end

    // frame for the phase being entered
    sntseq_frame #(
        .MAX_PAGE_LOG2 (MAX_PAGE_LOG2)
    ) u_frame (
        .i_phase     (n_phase),
        .i_address   (n_next_address),
        .i_chunk     (n_chunk),
        .i_total     (n_total_moved),
        .i_page_log2 (eff_log2),
        .o_frame     (frame)
    );

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_write_mode   <= 1'b0;
            r_next_address <= '0;
            r_bytes_left   <= '0;
            r_total_moved  <= '0;
            r_chunk        <= '0;
        end else if (proc) begin
            r_phase        <= n_phase;
            r_write_mode   <= n_write_mode;
            r_next_address <= n_next_address;
            r_bytes_left   <= n_bytes_left;
            r_total_moved  <= n_total_moved;
            r_chunk        <= n_chunk;
        end
    end

    // end-of-chunk sums, settled before the last poll of a chunk completes
    always_ff @(posedge i_clk) begin
        r_addr_after  <= r_next_address + 32'(r_chunk);
        r_left_after  <= r_bytes_left - 32'(r_chunk);
        r_total_after <= r_total_moved + 32'(r_chunk);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= res_valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res_valid) begin
            r_out_kind  <= res_finish;
            r_out_frame <= res_finish ? t_frame'('0) : frame;
            r_out_moved <= res_finish ? n_total_moved : 32'd0;
            r_out_early <= res_early;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_result_kind      = r_out_kind;
    assign o_command_byte     = r_out_frame.cmd;
    assign o_header_value     = r_out_frame.hdr_value;
    assign o_header_bytes     = r_out_frame.hdr_bytes;
    assign o_data_bytes       = r_out_frame.data_bytes;
    assign o_data_from_device = r_out_frame.from_dev;
    assign o_buffer_offset    = r_out_frame.offset;
    assign o_bytes_moved      = r_out_moved;
    assign o_ended_early      = r_out_early;

    // an open request always has a nonzero chunk no larger than a page
    a_chunk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> (r_chunk != '0 && r_chunk <= page_span))
        else $error("open request with empty or oversized chunk");

    // a finish word closes the request
    a_finish_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && res_valid && res_finish) |=> r_phase == PH_IDLE)
        else $error("finish issued but request still open");

    // a held word that is not decided blocks the input side
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid && !i_ready))
        else $error("input stalled without a full output register");

    // a completion while idle never produces a result
    a_idle_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_op == OP_DONE && r_phase == PH_IDLE) |=> !r_out_valid)
        else $error("result produced by completion while idle");

endmodule

[tb/sntseq_frame_check.sv]
// sntseq_frame_check: watches both word channels of the SPI NAND transfer sequencer,
// keeps its own copy of the sequencer state and checks every frame and finish word in order
// depends on sntseq_pkg for the phase type, opcodes and command bytes
module sntseq_frame_check import sntseq_pkg::*; #(
    parameter int MAX_PAGE_LOG2 = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    // input word channel
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_byte_address,
    input  logic [31:0] i_byte_count,
    input  logic        i_frame_ok,
    input  logic [7:0]  i_status_byte,
    // result word channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_result_kind,
    input  logic [7:0]  i_command_byte,
    input  logic [23:0] i_header_value,
    input  logic [1:0]  i_header_bytes,
    input  logic [13:0] i_data_bytes,
    input  logic        i_data_from_device,
    input  logic [31:0] i_buffer_offset,
    input  logic [31:0] i_bytes_moved,
    input  logic        i_ended_early,
    // status for the stimulus side
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_seq_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic RES_FRAME  = 1'b0;
    localparam logic RES_FINISH = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  cmd;
        logic [23:0] hdr_value;
        logic [1:0]  hdr_bytes;
        logic [13:0] data_bytes;
        logic        from_dev;
        logic [31:0] offset;
        logic [31:0] moved;
        logic        early;
    } t_seq_word;

    // predicted sequencer state
    t_phase      seq_ph;
    logic        wr_req;
    logic [31:0] cur_addr;
    logic [31:0] left_bytes;
    logic [31:0] moved_bytes;
    logic [13:0] chunk_len;
    logic [3:0]  page_log2_reg;

    t_seq_word   expected_words[$];
    int          fail_count;
    int          checked_words;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result word %0d: %s", $time, checked_words, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    // register value clamped to the supported page sizes
    function automatic int page_log2_eff();
        int v;
        v = int'(page_log2_reg);
        if (v < int'(MIN_PAGE_LOG2)) v = int'(MIN_PAGE_LOG2);
        if (v > MAX_PAGE_LOG2) v = MAX_PAGE_LOG2;
        return v;
    endfunction

    function automatic logic [31:0] cur_col();
        return cur_addr & ((32'd1 << page_log2_eff()) - 32'd1);
    endfunction

    function automatic logic [23:0] cur_page();
        logic [31:0] p;
        p = cur_addr >> page_log2_eff();
        return p[23:0];
    endfunction

    // phase after a successful frame within a chunk
    function automatic t_phase phase_after(input t_phase ph);
        case (ph)
            PH_R_PAGE:  return PH_R_POLLA;
            PH_R_POLLA: return PH_R_CACHE;
            PH_R_CACHE: return PH_R_POLLB;
            PH_W_WREN:  return PH_W_POLLA;
            PH_W_POLLA: return PH_W_LOAD;
            PH_W_LOAD:  return PH_W_POLLB;
            PH_W_POLLB: return PH_W_EXEC;
            PH_W_EXEC:  return PH_W_POLLC;
            default:    return PH_IDLE;
        endcase
    endfunction

    // frame described by the current phase
    function automatic t_seq_word frame_word();
        t_seq_word   w;
        logic [31:0] col;
        w = '0;
        col = cur_col();
        w.kind = RES_FRAME;
        case (seq_ph)
            PH_R_PAGE: begin
                w.cmd = CMD_PAGE_READ;
                w.hdr_value = cur_page();
                w.hdr_bytes = 2'd3;
            end
            PH_R_CACHE: begin
                w.cmd = CMD_CACHE_RD;
                w.hdr_value = {col[15:0], 8'h00};
                w.hdr_bytes = 2'd3;
                w.data_bytes = chunk_len;
                w.from_dev = 1'b1;
                w.offset = moved_bytes;
            end
            PH_W_WREN: begin
                w.cmd = CMD_WREN;
            end
            PH_W_LOAD: begin
                w.cmd = CMD_PROG_LOAD;
                w.hdr_value = col[23:0];
                w.hdr_bytes = 2'd2;
                w.data_bytes = chunk_len;
                w.offset = moved_bytes;
            end
            PH_W_EXEC: begin
                w.cmd = CMD_PROG_EXEC;
                w.hdr_value = cur_page();
                w.hdr_bytes = 2'd3;
            end
            default: begin
                w.cmd = CMD_GET_FEAT;
                w.hdr_value = {16'h0000, STATUS_REG};
                w.hdr_bytes = 2'd1;
                w.data_bytes = 14'd1;
                w.from_dev = 1'b1;
            end
        endcase
        return w;
    endfunction

    task automatic push_finish(input logic early);
        t_seq_word w;
        w = '0;
        w.kind = RES_FINISH;
        w.moved = moved_bytes;
        w.early = early;
        expected_words.push_back(w);
        seq_ph = PH_IDLE;
    endtask

    // size the next chunk up to the page end and go to its first frame
    task automatic open_chunk();
        logic [31:0] room;
        room = (32'd1 << page_log2_eff()) - cur_col();
        chunk_len = (left_bytes < room) ? left_bytes[13:0] : room[13:0];
        seq_ph = wr_req ? PH_W_WREN : PH_R_PAGE;
        expected_words.push_back(frame_word());
    endtask

    // advance the sequencer copy by one accepted word
    task automatic predict_word(input logic [1:0] op, input logic [31:0] addr,
                                input logic [31:0] cnt, input logic ok,
                                input logic [7:0] status);
        logic busy;
        busy = ok && status[0];
        if (op == OP_READ || op == OP_WRITE) begin
            if (seq_ph == PH_IDLE) begin
                wr_req = (op == OP_WRITE);
                cur_addr = addr;
                left_bytes = cnt;
                moved_bytes = '0;
                chunk_len = '0;
                if (cnt == 32'd0) push_finish(1'b0);
                else open_chunk();
            end
        end else if (op == OP_DONE && seq_ph != PH_IDLE) begin
            case (seq_ph) inside
                PH_R_PAGE, PH_R_CACHE, PH_W_WREN, PH_W_LOAD, PH_W_EXEC: begin
                    if (!ok) begin
                        push_finish(1'b1);
                    end else begin
                        seq_ph = phase_after(seq_ph);
                        expected_words.push_back(frame_word());
                    end
                end
                PH_R_POLLA, PH_W_POLLA, PH_W_POLLB: begin
                    if (!busy) seq_ph = phase_after(seq_ph);
                    expected_words.push_back(frame_word());
                end
                default: begin
                    // last poll of a chunk
                    if (busy) begin
                        expected_words.push_back(frame_word());
                    end else begin
                        cur_addr = cur_addr + 32'(chunk_len);
                        moved_bytes = moved_bytes + 32'(chunk_len);
                        left_bytes = left_bytes - 32'(chunk_len);
                        if (left_bytes == 32'd0) push_finish(1'b0);
                        else open_chunk();
                    end
                end
            endcase
        end
    endtask

    // one process: compare results, track the register, predict new words
    always @(posedge i_clk) begin : track
        t_seq_word got;
        t_seq_word want;
        if (!i_rst_n) begin
            seq_ph = PH_IDLE;
            wr_req = 1'b0;
            cur_addr = '0;
            left_bytes = '0;
            moved_bytes = '0;
            chunk_len = '0;
            page_log2_reg = RESET_PAGE_LOG2;
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.kind = i_result_kind;
                got.cmd = i_command_byte;
                got.hdr_value = i_header_value;
                got.hdr_bytes = i_header_bytes;
                got.data_bytes = i_data_bytes;
                got.from_dev = i_data_from_device;
                got.offset = i_buffer_offset;
                got.moved = i_bytes_moved;
                got.early = i_ended_early;
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, kind %0d command 0x%0h",
                                              got.kind, got.cmd));
                end else begin
                    want = expected_words.pop_front();
                    compare_field("result_kind", 32'(got.kind), 32'(want.kind));
                    compare_field("command_byte", 32'(got.cmd), 32'(want.cmd));
                    compare_field("header_value", 32'(got.hdr_value), 32'(want.hdr_value));
                    compare_field("header_bytes", 32'(got.hdr_bytes), 32'(want.hdr_bytes));
                    compare_field("data_bytes", 32'(got.data_bytes), 32'(want.data_bytes));
                    compare_field("data_from_device", 32'(got.from_dev),
                                  32'(want.from_dev));
                    compare_field("buffer_offset", got.offset, want.offset);
                    compare_field("bytes_moved", got.moved, want.moved);
                    compare_field("ended_early", 32'(got.early), 32'(want.early));
                end
                checked_words++;
            end
            if (i_cfg_we) page_log2_reg = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                predict_word(i_opcode, i_byte_address, i_byte_count, i_frame_ok,
                             i_status_byte);
            end
        end
        o_pending <= expected_words.size();
        o_seq_idle <= (seq_ph == PH_IDLE);
        o_fail_count <= fail_count;
    end

endmodule

[tb/spi_nand_transfer_sequencer_top_tb.sv]
// spi_nand_transfer_sequencer_top_tb: drives requests and completion reports into the
// sequencer, stalls both channels at random and prints the verdict
// depends on sntseq_pkg, spi_nand_transfer_sequencer_top and sntseq_frame_check
module spi_nand_transfer_sequencer_top_tb;
    import sntseq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_PAGE_LOG2 = 13;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int          RESET_CYCLES  = 11;
    localparam int          TOTAL_WORDS   = 1850;
    localparam int          CALM_WORDS    = 300;
    localparam int          CFG_STRIDE    = 180;
    localparam int          MAX_REPORTS   = 150;
    localparam int          HOLD_CYCLES   = 90;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          TIMEOUT_NS    = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = 4'd0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = OP_DONE;
    logic [31:0] i_byte_address = '0;
    logic [31:0] i_byte_count = '0;
    logic        i_frame_ok = 1'b0;
    logic [7:0]  i_status_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_command_byte;
    logic [23:0] o_header_value;
    logic [1:0]  o_header_bytes;
    logic [13:0] o_data_bytes;
    logic        o_data_from_device;
    logic [31:0] o_buffer_offset;
    logic [31:0] o_bytes_moved;
    logic        o_ended_early;

    int          fail_count;
    int          pending_words;
    logic        seq_idle;

    // stimulus controls shared with the result side
    int          words_sent = 0;
    bit          calm = 1'b0;
    int          tx_gap_pct = 0;
    int          hold_ask = 0;
    int          hold_done = 0;
    logic [31:0] page_bytes = 32'd2048;
    logic [3:0]  cfg_plan [8] = '{4'd13, 4'd0, 4'd15, 4'd12, 4'd10, 4'd8, 4'd14, 4'd11};

    spi_nand_transfer_sequencer_top #(.MAX_PAGE_LOG2(MAX_PAGE_LOG2)) dut (.*);

    sntseq_frame_check #(.MAX_PAGE_LOG2(MAX_PAGE_LOG2)) u_frame_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_opcode           (i_opcode),
        .i_byte_address     (i_byte_address),
        .i_byte_count       (i_byte_count),
        .i_frame_ok         (i_frame_ok),
        .i_status_byte      (i_status_byte),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_result_kind      (o_result_kind),
        .i_command_byte     (o_command_byte),
        .i_header_value     (o_header_value),
        .i_header_bytes     (o_header_bytes),
        .i_data_bytes       (o_data_bytes),
        .i_data_from_device (o_data_from_device),
        .i_buffer_offset    (o_buffer_offset),
        .i_bytes_moved      (o_bytes_moved),
        .i_ended_early      (o_ended_early),
        .o_fail_count       (fail_count),
        .o_pending          (pending_words),
        .o_seq_idle         (seq_idle)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("** spi_nand_transfer_sequencer_top: FAILED **");
        $finish;
    end

    // offer one word and hold it until accepted, with an optional gap first
    task automatic send_word(input logic [1:0] op, input logic [31:0] addr,
                             input logic [31:0] cnt, input logic ok,
                             input logic [7:0] status);
        int gap;
        if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_byte_address <= addr;
        i_byte_count   <= cnt;
        i_frame_ok     <= ok;
        i_status_byte  <= status;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // completion report with random filler in the unused fields
    task automatic send_report(input int ok_pct, input int busy_pct);
        logic [7:0] status;
        logic       ok;
        status = 8'($urandom);
        status[0] = ($urandom_range(0, 99) < busy_pct);
        ok = ($urandom_range(0, 99) < ok_pct);
        send_word(OP_DONE, $urandom, $urandom, ok, status);
    endtask

    // stop offering and wait until every expected word has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_page_log2(input logic [3:0] v);
        int eff;
        eff = (v < MIN_PAGE_LOG2) ? int'(MIN_PAGE_LOG2) :
              ((int'(v) > MAX_PAGE_LOG2) ? MAX_PAGE_LOG2 : int'(v));
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        page_bytes = 32'd1 << eff;
    endtask

    // one request followed by reports until it closes; long ones are cut short
    // seq_idle is a registered flag that trails the last accepted word, so a start sent
    // last is always followed by one more word before the idle flag is trusted
    task automatic run_request();
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] cnt;
        int          busy_pct;
        int          ok_pct;
        int          n;
        bit          last_start;
        op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        case ($urandom_range(0, 3))
            0:       addr = $urandom;
            1:       addr = ($urandom & ~(page_bytes - 32'd1)) - $urandom_range(0, 8);
            2:       addr = 32'hFFFF_FFFF - $urandom_range(0, 2 * page_bytes);
            default: addr = $urandom_range(0, 2 * page_bytes);
        endcase
        case ($urandom_range(0, 9)) inside
            0:          cnt = 32'd0;
            1:          cnt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
            2, 3, 4, 5: cnt = $urandom_range(1, page_bytes);
            default:    cnt = $urandom_range(1, 3 * page_bytes);
        endcase
        busy_pct = $urandom_range(0, 40);
        ok_pct = 100 - $urandom_range(0, 5);
        send_word(op, addr, cnt, 1'($urandom), 8'($urandom));
        n = 0;
        do begin
            last_start = 1'b0;
            case ($urandom_range(0, 49))
                0: begin
                    send_word($urandom_range(0, 1) ? OP_WRITE : OP_READ, $urandom,
                              $urandom, 1'($urandom), 8'($urandom));
                    last_start = 1'b1;
                end
                1:       send_word(OP_UNUSED, $urandom, $urandom, 1'($urandom),
                                   8'($urandom));
                default: send_report(ok_pct, busy_pct);
            endcase
            n++;
        end while ((!seq_idle || last_start) && n < MAX_REPORTS);
        // a failed command frame closes whatever is still open
        while (!seq_idle || last_start) begin
            send_word(OP_DONE, $urandom, $urandom, 1'b0, 8'($urandom));
            last_start = 1'b0;
        end
    endtask

    // result side: random stalls, one long hold on request, none near the end
    initial begin : result_sink
        int stall_pct;
        int cyc;
        int next_pick;
        int n;
        stall_pct = 0;
        cyc = 0;
        next_pick = 0;
        @(posedge i_clk);
        forever begin
            if (cyc >= next_pick) begin
                case ($urandom_range(0, 3)) inside
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 10;
                    default: stall_pct = 35;
                endcase
                next_pick = cyc + 150;
            end
            if (hold_ask != hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                cyc += HOLD_CYCLES;
                hold_done++;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                n = $urandom_range(1, 19);
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                cyc += n;
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
                cyc++;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int cfg_idx;
        int next_cfg_at;
        cfg_idx = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // last byte of the address space at the reset page size, busy and failed polls
        send_word(OP_READ, 32'hFFFF_FFFF, 32'd1, 1'b1, 8'h00);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b1, 8'h00);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b1, 8'hFF);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b0, 8'h01);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b1, 8'h00);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b1, 8'hFE);
        drain();
        set_page_log2(4'd9);

        // zero counts, report while idle, unused opcode
        send_word(OP_WRITE, 32'd0, 32'd0, 1'b0, 8'h00);
        send_word(OP_READ, 32'hFFFF_FFFF, 32'd0, 1'b1, 8'hFF);
        send_word(OP_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'h00);
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF);

        // largest count, start while busy, write enable fails
        send_word(OP_WRITE, 32'd0, 32'hFFFF_FFFF, 1'b1, 8'h00);
        send_word(OP_READ, 32'd0, 32'd4, 1'b1, 8'h00);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b0, 8'h00);

        // write across a page boundary, second chunk fails at write enable
        send_word(OP_WRITE, 32'h0000_01F0, 32'h0000_0020, 1'b1, 8'h00);
        repeat (6) send_word(OP_DONE, 32'd0, 32'd0, 1'b1, 8'h00);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b0, 8'h00);

        // read that fails at the cache read
        send_word(OP_READ, 32'd0, 32'd5, 1'b1, 8'h00);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b1, 8'h00);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b1, 8'h00);
        send_word(OP_DONE, 32'd0, 32'd0, 1'b0, 8'h00);

        // random requests, page size changed between phases
        next_cfg_at = words_sent;
        while (words_sent < TOTAL_WORDS) begin
            if (words_sent >= next_cfg_at) begin
                drain();
                set_page_log2(cfg_idx < 8 ? cfg_plan[cfg_idx] : 4'($urandom));
                cfg_idx++;
                next_cfg_at += CFG_STRIDE;
            end
            calm = (words_sent >= TOTAL_WORDS - CALM_WORDS);
            case ($urandom_range(0, 3)) inside
                0, 1:    tx_gap_pct = 0;
                2:       tx_gap_pct = 10;
                default: tx_gap_pct = 30;
            endcase
            // result side holds off while words keep coming, filling the block
            if (hold_ask == 0 && words_sent >= TOTAL_WORDS / 3) begin
                tx_gap_pct = 0;
                hold_ask++;
            end
            run_request();
        end

        drain();
        if (fail_count == 0 && pending_words == 0) begin
            $display("** spi_nand_transfer_sequencer_top: PASSED **");
        end else begin
            $display("** spi_nand_transfer_sequencer_top: FAILED **");
        end
        $finish;
    end

endmodule
